// ----- src/assert_macros.svh -----
// Assertion macros for the RTL; included by the table unit.
// Each sampled on the rising edge of clk and held off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every sampled edge.
`define ARRT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("arrt assertion failed");

// Expression must never be true at a sampled edge.
`define ARRT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("arrt forbidden condition seen");

`else

`define ARRT_ASSERT(lbl, prop)
`define ARRT_NEVER(lbl, expr)

`endif

`endif

// ----- src/arrt_pkg.sv -----
package arrt_pkg;

	// table geometry
	localparam int SLOTS = 16;
	localparam int IDXW  = $clog2(SLOTS);
	localparam int SLW   = 4;
	localparam int CMPW  = (IDXW > SLW) ? IDXW : SLW;
	localparam int AW    = 64;
	localparam int EW    = AW + 1;

	typedef logic [IDXW-1:0] idx_t;

	typedef enum logic {
		OP_REQUEST = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_GRANT    = 3'd0,
		ST_EXACT    = 3'd1,
		ST_OVERLAP  = 3'd2,
		ST_ZERO     = 3'd3,
		ST_FULL     = 3'd4,
		ST_RELEASED = 3'd5,
		ST_EMPTY    = 3'd6
	} status_t;

	// request travelling down the row of cells
	typedef struct packed {
		logic          space;
		logic [AW-1:0] base;
		logic [EW-1:0] rng_end;
		logic          hit;
		logic          exact;
		idx_t          hit_idx;
		logic          free;
		idx_t          free_idx;
	} token_t;

	// table update broadcast to every cell
	typedef struct packed {
		logic           grant;
		idx_t           grant_idx;
		logic           space;
		logic [AW-1:0]  base;
		logic [EW-1:0]  rng_end;
		logic           rel;
		logic [SLW-1:0] rel_slot;
	} upd_t;

endpackage

// ----- src/arrt_cell.sv -----
module arrt_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  arrt_pkg::idx_t     cell_idx,
	input  logic               act_in,
	input  arrt_pkg::token_t   tok_in,
	input  arrt_pkg::upd_t     upd,
	output logic               act_out,
	output arrt_pkg::token_t   tok_out,
	output logic               valid,
	output logic               rel_hit
);
	import arrt_pkg::*;

	logic          valid_q;
	logic          space_q;
	logic [AW-1:0] base_q;
	logic [EW-1:0] end_q;
	logic          act_q;
	token_t        tok_q;
	token_t        tok_nxt;
	logic          rel_match;
	logic          grant_match;
	logic          overlap;

	assign rel_match   = CMPW'(cell_idx) == CMPW'(upd.rel_slot);
	assign grant_match = upd.grant && (upd.grant_idx == cell_idx);
	assign rel_hit     = valid_q && rel_match;
	assign valid       = valid_q;
	assign act_out     = act_q;
	assign tok_out     = tok_q;

	// slot occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (grant_match) begin
			valid_q <= 1'b1;
		end else if (upd.rel && rel_match) begin
			valid_q <= 1'b0;
		end
	end

	// held range, end kept at 65 bits
	always_ff @(posedge clk) begin
		if (grant_match) begin
			space_q <= upd.space;
			base_q  <= upd.base;
			end_q   <= upd.rng_end;
		end
	end

	// overlap check against the passing request
	assign overlap = valid_q && (space_q == tok_in.space)
		&& ({1'b0, tok_in.base} < end_q) && ({1'b0, base_q} < tok_in.rng_end);

	always_comb begin
		tok_nxt = tok_in;
		if (!tok_in.hit && overlap) begin
			tok_nxt.hit     = 1'b1;
			tok_nxt.exact   = (base_q == tok_in.base) && (end_q == tok_in.rng_end);
			tok_nxt.hit_idx = cell_idx;
		end
		if (!tok_in.free && !valid_q) begin
			tok_nxt.free     = 1'b1;
			tok_nxt.free_idx = cell_idx;
		end
	end

	// hand the request on to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else begin
			act_q <= act_in;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_nxt;
	end

endmodule

// ----- src/address_range_reservation_table_unit.sv -----
// Request: the request passes the launch register, then walks the row of 16 slot cells
// one cell per cycle; the result strobe (done) is registered from the last cell. Next
// request accepted at the edge that ends the done cycle, so none overlaps the last one.
// Release and zero-size: result in the cycle after start, next one accepted straight away.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset (arst_n low) frees every slot at once and drops any transaction in flight.
`include "assert_macros.svh"

module address_range_reservation_table_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      op,
	input  logic                      space,
	input  logic [63:0]               range_base,
	input  logic [63:0]               range_size,
	input  logic [3:0]                slot_in,
	output logic                      done,
	output logic [2:0]                status,
	output logic [3:0]                slot_out
);
	import arrt_pkg::*;

	logic            busy_q;
	logic            launch_act_q;
	token_t          launch_tok_q;
	logic            done_q;
	status_t         status_q;
	logic [SLW-1:0]  slot_q;

	logic            act_c [SLOTS+1];
	token_t          tok_c [SLOTS+1];
	logic [SLOTS-1:0] valid_vec;
	logic [SLOTS-1:0] rel_hit_vec;
	logic [SLOTS:0]  act_vec;

	logic            accept;
	logic            is_release;
	logic            rel_ok;
	logic            fin;
	token_t          tok_last;
	upd_t            upd;

	assign accept     = start && !busy_q;
	assign is_release = op_t'(op) == OP_RELEASE;
	assign rel_ok     = |rel_hit_vec;
	assign fin        = act_c[SLOTS];
	assign tok_last   = tok_c[SLOTS];

	// row of slot cells
	assign act_c[0] = launch_act_q;
	assign tok_c[0] = launch_tok_q;

	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		arrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDXW'(g)),
			.act_in   (act_c[g]),
			.tok_in   (tok_c[g]),
			.upd      (upd),
			.act_out  (act_c[g+1]),
			.tok_out  (tok_c[g+1]),
			.valid    (valid_vec[g]),
			.rel_hit  (rel_hit_vec[g])
		);
	end

	for (genvar g = 0; g <= SLOTS; g++) begin : g_act
		assign act_vec[g] = act_c[g];
	end

	// table update: grant at the end of a scan, release straight from the port
	always_comb begin
		upd.grant     = fin && !tok_last.hit && tok_last.free;
		upd.grant_idx = tok_last.free_idx;
		upd.space     = tok_last.space;
		upd.base      = tok_last.base;
		upd.rng_end   = tok_last.rng_end;
		upd.rel       = accept && is_release && rel_ok;
		upd.rel_slot  = slot_in;
	end

	// control: busy and launch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			launch_act_q <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			launch_act_q <= accept && !is_release && (range_size != '0);
			if (accept && !is_release && (range_size != '0)) begin
				busy_q <= 1'b1;
			end else if (fin) begin
				busy_q <= 1'b0;
			end
			done_q <= fin || (accept && (is_release || (range_size == '0)));
		end
	end

	// request token, end formed at 65 bits
	always_ff @(posedge clk) begin
		if (accept) begin
			launch_tok_q.space    <= space;
			launch_tok_q.base     <= range_base;
			launch_tok_q.rng_end  <= {1'b0, range_base} + {1'b0, range_size};
			launch_tok_q.hit      <= 1'b0;
			launch_tok_q.exact    <= 1'b0;
			launch_tok_q.hit_idx  <= '0;
			launch_tok_q.free     <= 1'b0;
			launch_tok_q.free_idx <= '0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (fin) begin
			if (tok_last.hit) begin
				if (tok_last.exact) begin
					status_q <= ST_EXACT;
					slot_q   <= SLW'(tok_last.hit_idx);
				end else begin
					status_q <= ST_OVERLAP;
					slot_q   <= '0;
				end
			end else if (tok_last.free) begin
				status_q <= ST_GRANT;
				slot_q   <= SLW'(tok_last.free_idx);
			end else begin
				status_q <= ST_FULL;
				slot_q   <= '0;
			end
		end else if (accept && is_release) begin
			status_q <= rel_ok ? ST_RELEASED : ST_EMPTY;
			slot_q   <= rel_ok ? slot_in : '0;
		end else if (accept && (range_size == '0)) begin
			status_q <= ST_ZERO;
			slot_q   <= '0;
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign status   = status_q;
	assign slot_out = slot_q;

	// checks
	`ARRT_ASSERT(a_one_token, $countones(act_vec) <= 1)
	`ARRT_NEVER(a_done_while_busy, done_q && busy_q)
	`ARRT_ASSERT(a_grant_fills, upd.grant |=> ($countones(valid_vec) == $past($countones(valid_vec)) + 1))
	`ARRT_ASSERT(a_release_frees, upd.rel |=> ($countones(valid_vec) + 1 == $past($countones(valid_vec))))
	`ARRT_ASSERT(a_full_means_full, (fin && !tok_last.hit && !tok_last.free) |-> (&valid_vec))

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
	import arrt_pkg::*;

	localparam int RAND_CMDS    = 1300;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int MAX_GAP      = 24;
	localparam int DRAIN_CYCLES = 40;
	localparam int REPORT_MAX   = 10;

	// one command to the table, and the answer it should give
	typedef struct {
		op_t            op;
		logic           space;
		logic [63:0]    base;
		logic [63:0]    size;
		logic [SLW-1:0] slot;
	} table_cmd_t;

	typedef struct {
		status_t        status;
		logic [SLW-1:0] slot;
	} table_reply_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           start = 1'b0;
	logic           op = 1'b0;
	logic           space = 1'b0;
	logic [63:0]    range_base = '0;
	logic [63:0]    range_size = '0;
	logic [3:0]     slot_in = '0;
	logic           busy;
	logic           done;
	logic [2:0]     status;
	logic [3:0]     slot_out;

	// stimulus and expected replies
	table_cmd_t     cmd_q[$];
	table_cmd_t     recent_q[$];
	table_reply_t   reply_q[$];
	table_cmd_t     offered;
	bit             taken;
	int             gap_left = 0;
	int             n_taken = 0;
	int             n_checked = 0;
	int             n_mismatch = 0;
	int             n_unexpected = 0;
	int             cycle_count = 0;
	int unsigned    status_seen[7];

	// shadow copy of the reservation table
	logic           held_valid[SLOTS];
	logic [63:0]    held_base[SLOTS];
	logic [63:0]    held_size[SLOTS];
	logic           held_space[SLOTS];

	address_range_reservation_table_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.space      (space),
		.range_base (range_base),
		.range_size (range_size),
		.slot_in    (slot_in),
		.done       (done),
		.status     (status),
		.slot_out   (slot_out)
	);

	always #5 clk = ~clk;

	// apply one command to the shadow table and return the reply it earns
	function automatic table_reply_t table_apply(input table_cmd_t c);
		table_reply_t r;
		logic [64:0]  new_end;
		logic [64:0]  held_end;
		logic         hit;
		logic         exact;
		int           i;
		r.status = ST_EMPTY;
		r.slot = '0;
		hit = 1'b0;
		exact = 1'b0;
		if (c.op == OP_RELEASE) begin
			if (int'(c.slot) < SLOTS && held_valid[c.slot]) begin
				held_valid[c.slot] = 1'b0;
				r.status = ST_RELEASED;
				r.slot = c.slot;
			end
		end else if (c.size == '0) begin
			r.status = ST_ZERO;
		end else begin
			// ends at 65 bits so ranges reaching past the top never wrap
			new_end = {1'b0, c.base} + {1'b0, c.size};
			for (i = 0; i < SLOTS; i++) begin
				held_end = {1'b0, held_base[i]} + {1'b0, held_size[i]};
				if (!hit && held_valid[i] && held_space[i] == c.space &&
						{1'b0, c.base} < held_end && {1'b0, held_base[i]} < new_end) begin
					hit = 1'b1;
					exact = held_base[i] == c.base && held_size[i] == c.size;
					if (exact)
						r.slot = SLW'(i);
				end
			end
			if (hit) begin
				r.status = exact ? ST_EXACT : ST_OVERLAP;
			end else begin
				r.status = ST_FULL;
				for (i = 0; i < SLOTS; i++) begin
					if (r.status == ST_FULL && !held_valid[i]) begin
						held_valid[i] = 1'b1;
						held_base[i] = c.base;
						held_size[i] = c.size;
						held_space[i] = c.space;
						r.status = ST_GRANT;
						r.slot = SLW'(i);
					end
				end
			end
		end
		return r;
	endfunction

	// ignored fields carry random noise
	function automatic table_cmd_t mk_req(input logic sp, input logic [63:0] b,
			input logic [63:0] s);
		table_cmd_t c;
		c.op = OP_REQUEST;
		c.space = sp;
		c.base = b;
		c.size = s;
		c.slot = SLW'($urandom);
		return c;
	endfunction

	function automatic table_cmd_t mk_rel(input logic [SLW-1:0] sl);
		table_cmd_t c;
		c.op = OP_RELEASE;
		c.space = 1'($urandom);
		c.base = {$urandom, $urandom};
		c.size = {$urandom, $urandom};
		c.slot = sl;
		return c;
	endfunction

	// draw the next random command: a release, a repeat of a recent request, or a new request
	function automatic table_cmd_t rand_cmd();
		table_cmd_t c;
		int         roll;
		roll = $urandom_range(0, 99);
		if (roll < 28)
			c = mk_rel(SLW'($urandom_range(0, 15)));
		else if (roll < 48 && recent_q.size() != 0)
			c = recent_q[$urandom_range(0, recent_q.size() - 1)];
		else if (roll < 78)
			c = mk_req(1'($urandom), 64'($urandom_range(0, 3) * 256 + $urandom_range(0, 255)),
				64'($urandom_range(1, 48)));
		else if (roll < 86)
			c = mk_req(1'($urandom), ~64'($urandom_range(0, 300)), 64'($urandom_range(1, 600)));
		else if (roll < 94)
			c = mk_req(1'($urandom), {$urandom, $urandom},
				{$urandom, $urandom} >> $urandom_range(0, 63));
		else
			c = mk_req(1'($urandom), {$urandom, $urandom}, '0);
		return c;
	endfunction

	// driver: offers the next queued command, holds it until taken
	always @(posedge clk) begin
		if (arst_n) begin
			taken = start && !busy;
			if (taken) begin
				reply_q.push_back(table_apply(offered));
				n_taken++;
				if ((n_taken >= 500 && n_taken < 800) || $urandom_range(0, 99) >= 33)
					gap_left = 0;
				else
					gap_left = $urandom_range(1, MAX_GAP);
			end
			if (start && !taken) begin
				// keep the transaction on the ports
			end else if (gap_left == 0 && cmd_q.size() != 0) begin
				offered = cmd_q.pop_front();
				start <= 1'b1;
				op <= offered.op;
				space <= offered.space;
				range_base <= offered.base;
				range_size <= offered.size;
				slot_in <= offered.slot;
			end else begin
				if (gap_left != 0)
					gap_left--;
				start <= 1'b0;
				op <= 1'($urandom);
				space <= 1'($urandom);
				range_base <= {$urandom, $urandom};
				range_size <= {$urandom, $urandom};
				slot_in <= 4'($urandom);
			end
		end
	end

	// monitor: every strobed reply against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (reply_q.size() == 0) begin
				n_unexpected++;
				if (n_unexpected + n_mismatch <= REPORT_MAX)
					$display("tb_top: reply with nothing pending: status %0d slot %0d",
						status, slot_out);
			end else begin
				table_reply_t want;
				want = reply_q.pop_front();
				n_checked++;
				if (status !== want.status || slot_out !== want.slot) begin
					n_mismatch++;
					if (n_unexpected + n_mismatch <= REPORT_MAX)
						$display("tb_top: reply %0d: expected %s slot %0d, got status %0d slot %0d",
							n_checked, want.status.name(), want.slot, status, slot_out);
				end else begin
					status_seen[status]++;
				end
			end
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: cycle limit reached with %0d replies pending", reply_q.size());
			$display("tb_top: done, errors");
			$finish;
		end
	end

	initial begin
		int k;
		table_cmd_t c;
		for (k = 0; k < SLOTS; k++) begin
			held_valid[k] = 1'b0;
			held_base[k] = '0;
			held_size[k] = '0;
			held_space[k] = 1'b0;
		end
		for (k = 0; k < 7; k++)
			status_seen[k] = 0;

		// directed: empty releases, zero size, exact and partial overlap,
		// ranges past the top of the space, a full table, release twice
		cmd_q.push_back(mk_rel(4'd0));
		cmd_q.push_back(mk_rel(4'd15));
		cmd_q.push_back(mk_req(1'b0, 64'd0, 64'd0));
		cmd_q.push_back(mk_req(1'b0, 64'd0, 64'd1));
		cmd_q.push_back(mk_req(1'b0, 64'd0, 64'd1));
		cmd_q.push_back(mk_req(1'b1, 64'd0, 64'd1));
		cmd_q.push_back(mk_req(1'b0, 64'd0, 64'd2));
		cmd_q.push_back(mk_req(1'b0, '1, '1));
		cmd_q.push_back(mk_req(1'b0, 64'd5, '1));
		for (k = 1; k <= 13; k++)
			cmd_q.push_back(mk_req(1'b1, 64'(16 * k), 64'd16));
		cmd_q.push_back(mk_req(1'b1, 64'd1000, 64'd1));
		cmd_q.push_back(mk_req(1'b1, 64'd16, 64'd16));
		cmd_q.push_back(mk_rel(4'd15));
		cmd_q.push_back(mk_rel(4'd15));

		// random: mostly small ranges in a few windows, with repeats of
		// recent requests so that exact matches keep turning up
		for (k = 0; k < RAND_CMDS; k++) begin
			c = rand_cmd();
			if (c.op == OP_REQUEST && c.size != '0) begin
				recent_q.push_back(c);
				if (recent_q.size() > 24)
					void'(recent_q.pop_front());
			end
			cmd_q.push_back(c);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_q.size() != 0 || start || reply_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb_top: %0d transactions, %0d replies checked (grant %0d, exact %0d, overlap %0d,",
			n_taken, n_checked, status_seen[ST_GRANT], status_seen[ST_EXACT],
			status_seen[ST_OVERLAP]);
		$display("tb_top: zero %0d, full %0d, released %0d, empty %0d), %0d bad, %0d stray",
			status_seen[ST_ZERO], status_seen[ST_FULL], status_seen[ST_RELEASED],
			status_seen[ST_EMPTY], n_mismatch, n_unexpected);
		if (n_mismatch == 0 && n_unexpected == 0 && reply_q.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+src
src/arrt_pkg.sv
src/arrt_cell.sv
src/address_range_reservation_table_unit.sv
test/tb_top.sv
